>>> hdl/qbvb_pkg.sv
// Shared types and constants for the quad batch vertex builder.
`timescale 1ns / 1ps

package qbvb_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_COLOR = 2'd0,
        MODE_TEX   = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DRAW,
        ST_VERT
    } t_state;

    // Result kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_DRAW   = 1'b1;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int TILE_W     = 16;
    localparam int SLOT_W     = 4;
    localparam int IDX_W      = 17;
    localparam int LIMIT_W    = 15;
    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 168;

    // Output tdata field offsets
    localparam int OUT_CORNER_LO = 128;
    localparam int OUT_SLOT_LO   = 130;
    localparam int OUT_TILE_LO   = 134;
    localparam int OUT_IDX_LO    = 150;

    localparam logic [TILE_W-1:0]  TILE_ONE    = 16'd256;
    localparam logic [COORD_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

    // Commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic look;
        logic flush_quiet;
        logic emit_draw;
        logic emit_vertex;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic  in_valid;
        t_mode mode;
        logic  draw_needed;
        logic  quads_nonzero;
        logic  out_free;
        logic  last_corner;
    } t_status;

endpackage

>>> hdl/qbvb_datapath.sv
// Datapath: item register, slot table, batch counters, corner math and output register.
`timescale 1ns / 1ps

module qbvb_datapath #(
    parameter int TEX_SLOTS       = 16,
    parameter int MAX_BATCH_QUADS = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qbvb_pkg::t_cmd                      i_cmd,
    output qbvb_pkg::t_status                   o_status,
    input  logic                                i_s_tvalid,
    input  logic [qbvb_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic [1:0]                          i_s_tuser,
    output logic                                o_s_tready,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [qbvb_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qbvb_pkg::LIMIT_W-1:0]        i_cfg_data
);

    localparam int NW = $clog2(TEX_SLOTS + 1);
    localparam int TW = $clog2(TEX_SLOTS);
    localparam int QW = $clog2(MAX_BATCH_QUADS + 1);
    localparam int CW = (QW > qbvb_pkg::LIMIT_W) ? QW : qbvb_pkg::LIMIT_W;
    localparam int IW = QW + 3;

    // Corner coordinate: floor((2c +/- s) / 2), saturated to 32 bits
    function automatic logic [31:0] corner_coord(input logic [31:0] c, input logic [31:0] s,
                                                 input logic plus);
        logic [33:0] v;
        logic [32:0] h;
        begin
            v = plus ? ({c[31], c, 1'b0} + {{2{s[31]}}, s})
                     : ({c[31], c, 1'b0} - {{2{s[31]}}, s});
            h = v[33:1];
            if (h[32] != h[31]) begin
                corner_coord = h[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                corner_coord = h[31:0];
            end
        end
    endfunction

    logic [qbvb_pkg::IN_DATA_W-1:0]  r_item;
    qbvb_pkg::t_mode                 r_mode;
    logic [31:0]                     r_slot_tab [TEX_SLOTS];
    logic [NW-1:0]                   r_next_slot;
    logic [QW-1:0]                   r_quads;
    logic [qbvb_pkg::LIMIT_W-1:0]    r_limit;
    logic [1:0]                      r_corner;
    logic                            r_hit;
    logic [NW-1:0]                   r_hit_slot;
    logic [NW-1:0]                   r_slot;
    logic                            r_out_valid;
    logic [qbvb_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_kind;
    logic                            r_out_last;

    logic [31:0] f_cx, f_cy, f_cz, f_w, f_h, f_rgba, f_tex;
    logic [15:0] f_tiling;
    logic        tex_mode, quad_mode, accept, first_corner, out_free;
    logic        hit_raw, hit_eff, limit_flush, full_flush;
    logic [NW-1:0] hit_idx, new_slot, cur_slot;
    logic [CW-1:0] lim_ext, eff_lim, q_ext;
    logic [IW-1:0] q6;
    logic [IW+qbvb_pkg::IDX_W-1:0] idx_ext;
    logic [NW+qbvb_pkg::SLOT_W-1:0] slot_ext;
    logic [qbvb_pkg::IDX_W-1:0] idx_count;
    logic        px, py;
    logic [qbvb_pkg::OUT_DATA_W-1:0] vert_data, draw_data;

    // Unpack the held item
    assign f_cx     = r_item[31:0];
    assign f_cy     = r_item[63:32];
    assign f_cz     = r_item[95:64];
    assign f_w      = r_item[127:96];
    assign f_h      = r_item[159:128];
    assign f_rgba   = r_item[191:160];
    assign f_tex    = r_item[223:192];
    assign f_tiling = r_item[239:224];

    assign tex_mode     = (r_mode == qbvb_pkg::MODE_TEX);
    assign quad_mode    = (r_mode == qbvb_pkg::MODE_COLOR) || (r_mode == qbvb_pkg::MODE_TEX);
    assign accept       = i_cmd.in_ready && i_s_tvalid;
    assign first_corner = (r_corner == 2'd0);
    assign out_free     = !r_out_valid || i_m_tready;

    // Clamp the batch limit into 1 .. MAX_BATCH_QUADS
    always_comb begin
        lim_ext = CW'(r_limit);
        q_ext   = CW'(r_quads);
        if (lim_ext == '0) begin
            eff_lim = CW'(1);
        end else if (lim_ext > CW'(MAX_BATCH_QUADS)) begin
            eff_lim = CW'(MAX_BATCH_QUADS);
        end else begin
            eff_lim = lim_ext;
        end
    end

    // Compare the texture id against every live slot; live ids are distinct
    always_comb begin
        hit_raw = 1'b0;
        hit_idx = '0;
        for (int i = 1; i < TEX_SLOTS; i++) begin
            if ((NW'(i) < r_next_slot) && (r_slot_tab[i] == f_tex)) begin
                hit_raw = 1'b1;
                hit_idx = hit_idx | NW'(i);
            end
        end
    end

    // Decide whether a draw has to go out before the vertices
    assign limit_flush = quad_mode && (q_ext >= eff_lim);
    assign hit_eff     = tex_mode && hit_raw && !limit_flush;
    assign full_flush  = tex_mode && !hit_eff && !limit_flush
                         && (r_next_slot >= NW'(TEX_SLOTS));

    // Slot of the current vertex
    assign new_slot = tex_mode ? (r_hit ? r_hit_slot : r_next_slot) : '0;
    assign cur_slot = first_corner ? new_slot : r_slot;
    assign slot_ext = {{qbvb_pkg::SLOT_W{1'b0}}, cur_slot};

    // Index count of a draw: six per quad
    assign q6        = (IW'(r_quads) << 2) + (IW'(r_quads) << 1);
    assign idx_ext   = {{qbvb_pkg::IDX_W{1'b0}}, q6};
    assign idx_count = idx_ext[qbvb_pkg::IDX_W-1:0];

    // Build the result payloads
    assign px = (r_corner == 2'd1) || (r_corner == 2'd2);
    assign py = r_corner[1];
    assign vert_data = {1'b0,
                        {qbvb_pkg::IDX_W{1'b0}},
                        tex_mode ? f_tiling : qbvb_pkg::TILE_ONE,
                        slot_ext[qbvb_pkg::SLOT_W-1:0],
                        r_corner,
                        tex_mode ? qbvb_pkg::COLOR_WHITE : f_rgba,
                        f_cz,
                        corner_coord(f_cy, f_h, py),
                        corner_coord(f_cx, f_w, px)};
    assign draw_data = {1'b0, idx_count, {qbvb_pkg::OUT_IDX_LO{1'b0}}};

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_s_tdata;
            r_mode <= qbvb_pkg::t_mode'(i_s_tuser);
        end
    end

    // Latch the lookup outcome and the quad's slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_hit      <= hit_eff;
            r_hit_slot <= hit_idx;
        end
        if (i_cmd.emit_vertex && first_corner) begin
            r_slot <= new_slot;
        end
    end

    // Record a new texture in the slot table
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_vertex && first_corner && tex_mode && !r_hit
            && (r_next_slot < NW'(TEX_SLOTS))) begin
            r_slot_tab[r_next_slot[TW-1:0]] <= f_tex;
        end
    end

    // Advance batch counters, corner and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quads     <= '0;
            r_next_slot <= NW'(1);
            r_corner    <= '0;
            r_limit     <= qbvb_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.emit_draw || i_cmd.flush_quiet) begin
                r_quads     <= '0;
                r_next_slot <= NW'(1);
            end else if (i_cmd.emit_vertex && first_corner) begin
                r_quads <= r_quads + QW'(1);
                if (tex_mode && !r_hit) begin
                    r_next_slot <= r_next_slot + NW'(1);
                end
            end
            if (i_cmd.emit_vertex) begin
                r_corner <= r_corner + 2'd1;
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_draw || i_cmd.emit_vertex) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_draw) begin
            r_out_data <= draw_data;
            r_out_kind <= qbvb_pkg::KIND_DRAW;
            r_out_last <= (r_mode == qbvb_pkg::MODE_FLUSH);
        end else if (i_cmd.emit_vertex) begin
            r_out_data <= vert_data;
            r_out_kind <= qbvb_pkg::KIND_VERTEX;
            r_out_last <= (r_corner == qbvb_pkg::CORNER_LAST);
        end
    end

    assign o_s_tready  = i_cmd.in_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_kind;
    assign o_m_tlast   = r_out_last;
    assign o_cfg_ready = 1'b1;

    assign o_status.in_valid      = i_s_tvalid;
    assign o_status.mode          = r_mode;
    assign o_status.draw_needed   = limit_flush || full_flush;
    assign o_status.quads_nonzero = (r_quads != '0);
    assign o_status.out_free      = out_free;
    assign o_status.last_corner   = (r_corner == qbvb_pkg::CORNER_LAST);

endmodule

>>> hdl/qbvb_ctrl.sv
// Controller state machine: sequences accept, slot lookup, draw and four vertices.
`timescale 1ns / 1ps

module qbvb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qbvb_pkg::t_status i_status,
    output qbvb_pkg::t_cmd    o_cmd
);

    qbvb_pkg::t_state r_state;
    qbvb_pkg::t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qbvb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            qbvb_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    n_state = qbvb_pkg::ST_LOOK;
                end
            end
            qbvb_pkg::ST_LOOK: begin
                o_cmd.look = 1'b1;
                case (i_status.mode)
                    qbvb_pkg::MODE_FLUSH: begin
                        if (i_status.quads_nonzero) begin
                            n_state = qbvb_pkg::ST_DRAW;
                        end else begin
                            o_cmd.flush_quiet = 1'b1;
                            n_state = qbvb_pkg::ST_IDLE;
                        end
                    end
                    qbvb_pkg::MODE_COLOR, qbvb_pkg::MODE_TEX: begin
                        n_state = i_status.draw_needed ? qbvb_pkg::ST_DRAW
                                                       : qbvb_pkg::ST_VERT;
                    end
                    default: begin
                        n_state = qbvb_pkg::ST_IDLE;
                    end
                endcase
            end
            qbvb_pkg::ST_DRAW: begin
                if (i_status.out_free) begin
                    o_cmd.emit_draw = 1'b1;
                    n_state = (i_status.mode == qbvb_pkg::MODE_FLUSH) ? qbvb_pkg::ST_IDLE
                                                                       : qbvb_pkg::ST_VERT;
                end
            end
            qbvb_pkg::ST_VERT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_vertex = 1'b1;
                    if (i_status.last_corner) begin
                        n_state = qbvb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = qbvb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/quad_batch_vertex_builder.sv
// Top level of the quad batch vertex builder: controller, datapath and checks.
`timescale 1ns / 1ps

// Turns quad requests into four corner vertices each, batching them into draws.
// One item is in work at a time. A colored or textured quad passes the accept
// step, one parallel slot-table compare, a draw command first when one is needed,
// and four vertices at one result per cycle while the master side does not stall;
// any stall on the master side holds the block. An end-of-scene item emits a draw
// only when the batch holds quads, and an item of the unused mode is dropped. The
// single output register sets the one-result-per-cycle pace. The next item is
// accepted while the last result still waits in the output register.
// The batch limit is written through the cfg channel, which is always ready.
module quad_batch_vertex_builder #(
    parameter int TEX_SLOTS       = 16,
    parameter int MAX_BATCH_QUADS = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // center_x, center_y, center_z, width, height, rgba, texture_id, tiling
    input  logic [qbvb_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]                      s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // vertex_x, vertex_y, vertex_z, vertex_color, corner, slot, tile_factor,
    // index_count, one pad bit
    output logic [qbvb_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic                            m_tuser,
    output logic                            m_tlast,
    // Batch limit register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qbvb_pkg::LIMIT_W-1:0]    i_cfg_data
);

    qbvb_pkg::t_cmd    cmd;
    qbvb_pkg::t_status status;

    qbvb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    qbvb_datapath #(
        .TEX_SLOTS       (TEX_SLOTS),
        .MAX_BATCH_QUADS (MAX_BATCH_QUADS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tvalid  (s_tvalid),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_s_tready  (s_tready),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive edges");

    // A draw never carries an empty batch
    a_draw_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == qbvb_pkg::KIND_DRAW)
        |-> (m_tdata[qbvb_pkg::OUT_IDX_LO +: qbvb_pkg::IDX_W] != '0))
        else $error("draw item with zero index count");

    // A vertex closes its item exactly at the last corner
    a_vertex_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == qbvb_pkg::KIND_VERTEX)
        |-> (m_tlast == (m_tdata[qbvb_pkg::OUT_CORNER_LO +: 2] == qbvb_pkg::CORNER_LAST)))
        else $error("vertex last flag out of step with corner");

    // A vertex item never carries an index count
    a_vertex_no_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == qbvb_pkg::KIND_VERTEX)
        |-> (m_tdata[qbvb_pkg::OUT_IDX_LO +: qbvb_pkg::IDX_W] == '0))
        else $error("vertex item with index count");

endmodule
